// ===== hw/rtl/lkv_pkg.sv =====
package lkv_pkg;

  localparam int KEY_W            = 32;
  localparam int VAL_W            = 32;
  localparam int CAP_W            = 5;
  localparam int CAPACITY_DEFAULT = 16;

  localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // request held in the input register
  typedef struct packed {
    logic             vld;
    logic             op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
  } req_t;

  // lookup outcome for the request in the input register
  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] val;
  } lookup_t;

endpackage

// ===== hw/rtl/lkv_entries.sv =====
module lkv_entries
  import lkv_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  req_t             req,
  input  logic [CAP_W-1:0] capacity,
  output lookup_t          lookup
);

  localparam int RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LIVE_W = $clog2(CAPACITY + 1);
  localparam int LIM_W  = (LIVE_W > CAP_W) ? LIVE_W : CAP_W;

  logic [KEY_W-1:0]  keys   [CAPACITY];
  logic [VAL_W-1:0]  values [CAPACITY];
  logic [RANK_W-1:0] ranks  [CAPACITY];
  logic [CAPACITY-1:0] valid;
  logic [LIVE_W-1:0]   live_count;

  logic [RANK_W-1:0] ranks_next [CAPACITY];
  logic [CAPACITY-1:0] valid_next;
  logic [LIVE_W-1:0]   live_count_next;
  logic [CAPACITY-1:0] key_we;
  logic [CAPACITY-1:0] val_we;

  logic [CAPACITY-1:0] hit_vec;
  logic [CAPACITY-1:0] evict_vec;
  logic [CAPACITY-1:0] avail;
  logic [CAPACITY-1:0] ins_oh;
  logic                hit_any;
  logic [VAL_W-1:0]    hit_val;
  logic [RANK_W-1:0]   hit_rank;
  logic [LIM_W-1:0]    limit;
  logic [LIVE_W-1:0]   live_m1;
  logic                need_evict;
  logic                do_insert;

  // effective limit: zero acts as one, saturate at the number of slots
  always_comb begin
    if (capacity == '0) begin
      limit = LIM_W'(1);
    end else if (LIM_W'(capacity) > LIM_W'(CAPACITY)) begin
      limit = LIM_W'(CAPACITY);
    end else begin
      limit = LIM_W'(capacity);
    end
  end

  assign live_m1    = live_count - LIVE_W'(1);
  assign need_evict = LIM_W'(live_count) >= limit;

  always_comb begin
    hit_val  = '0;
    hit_rank = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_vec[i]   = valid[i] && (keys[i] == req.key);
      evict_vec[i] = valid[i] && (LIVE_W'(ranks[i]) == live_m1);
      hit_val      = hit_val | (hit_vec[i] ? values[i] : '0);
      hit_rank     = hit_rank | (hit_vec[i] ? ranks[i] : '0);
    end
    hit_any = |hit_vec;
  end

  assign do_insert = req.vld && (req.op == OP_PUT) && !hit_any;

  // lowest free slot, counting the one freed by an eviction in the same cycle
  assign avail  = ~valid | ((do_insert && need_evict) ? evict_vec : '0);
  assign ins_oh = avail & (~avail + CAPACITY'(1));

  always_comb begin
    valid_next      = valid;
    live_count_next = live_count;
    key_we          = '0;
    val_we          = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      ranks_next[i] = ranks[i];
    end
    if (req.vld && hit_any) begin
      // move the hit entry to the front, newer entries age by one
      for (int i = 0; i < CAPACITY; i++) begin
        if (hit_vec[i]) begin
          ranks_next[i] = '0;
        end else if (valid[i] && ranks[i] < hit_rank) begin
          ranks_next[i] = ranks[i] + RANK_W'(1);
        end
      end
      if (req.op == OP_PUT) begin
        val_we = hit_vec;
      end
    end else if (do_insert) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (ins_oh[i]) begin
          valid_next[i] = 1'b1;
          ranks_next[i] = '0;
        end else if (need_evict && evict_vec[i]) begin
          valid_next[i] = 1'b0;
          ranks_next[i] = '0;
        end else if (valid[i]) begin
          ranks_next[i] = ranks[i] + RANK_W'(1);
        end
      end
      key_we = ins_oh;
      val_we = ins_oh;
      if (!need_evict) begin
        live_count_next = live_count + LIVE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      live_count <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        ranks[i] <= '0;
      end
    end else begin
      valid      <= valid_next;
      live_count <= live_count_next;
      for (int i = 0; i < CAPACITY; i++) begin
        ranks[i] <= ranks_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (key_we[i]) begin
        keys[i] <= req.key;
      end
      if (val_we[i]) begin
        values[i] <= req.val;
      end
    end
  end

  assign lookup.hit = hit_any;
  assign lookup.val = hit_val;

endmodule

// ===== hw/rtl/lru_key_value_cache.sv =====
// Fully associative key/value cache with least-recently-used replacement.
// A request is taken on any cycle with start high; busy never rises, so one
// request per clock is sustained. Each request is registered, then matched
// against every slot and applied to the slot array in the next cycle; a get
// returns its result on hit/read_value with result_valid high for exactly one
// cycle, out of the result register. A put returns nothing. The receiver
// cannot stall: results must be captured in the cycle they appear. A miss
// reads as all ones. capacity (via the cfg channel) limits how many slots
// fill before eviction starts; zero acts as one, values above CAPACITY act as
// CAPACITY. Write it only while no request is in flight.
module lru_key_value_cache
  import lkv_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    operation,
  input  logic signed [KEY_W-1:0] key,
  input  logic signed [VAL_W-1:0] value,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CAP_W-1:0]        cfg_data,
  output logic                    result_valid,
  output logic                    hit,
  output logic signed [VAL_W-1:0] read_value
);

  req_t             req;
  lookup_t          lookup;
  logic [CAP_W-1:0] capacity;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req.vld <= 1'b0;
    end else begin
      req.vld <= start && !busy;
      if (start && !busy) begin
        req.op  <= operation;
        req.key <= key;
        req.val <= value;
      end
    end
  end

  lkv_entries #(
    .CAPACITY(CAPACITY)
  ) u_entries (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .capacity (capacity),
    .lookup   (lookup)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= req.vld && (req.op == OP_GET);
    end
  end

  always_ff @(posedge clk) begin
    hit        <= lookup.hit;
    read_value <= lookup.hit ? lookup.val : MISS_VALUE;
  end

endmodule
